// ===== src/bfsk_pkg.sv =====
// ----------------------------------------------------------------------------
// bfsk_pkg
// Shared types, constants and tone tables for the binary FSK I/Q modulator.
// ----------------------------------------------------------------------------
package bfsk_pkg;

	// frame store and counter sizes
	localparam int FRAME_BYTES = 32;
	localparam int TONE_PERIOD = 10;
	localparam int POS_W       = $clog2(FRAME_BYTES);
	localparam int LEN_W       = $clog2(FRAME_BYTES + 1);
	localparam int TONE_W      = $clog2(TONE_PERIOD);
	localparam int SPB_W       = 12;
	localparam int BYTE_W      = 8;
	localparam int BIT_W       = 3;
	localparam int SAMPLE_W    = 8;

	// configuration port
	localparam int CFG_W       = SPB_W;
	localparam int REG_IDX_W   = 1;
	localparam logic [REG_IDX_W-1:0] REG_SPB          = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_LENGTH = 1'b1;

	localparam logic [SPB_W-1:0] SPB_RESET  = 12'd400;
	localparam logic [LEN_W-1:0] FLEN_RESET = LEN_W'(FRAME_BYTES);

	// item opcodes
	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SAMPLE = 1'b1
	} opcode_t;

	// sequencer position handed to the sample path
	typedef struct packed {
		logic [POS_W-1:0]  byte_pos;
		logic [BIT_W-1:0]  bit_pos;
		logic [TONE_W-1:0] tone;
		logic              frame_end;
	} seq_status_t;

	// 120*cos(2*pi*k/10), truncated toward zero
	function automatic logic signed [SAMPLE_W-1:0] i_sample(input logic [TONE_W-1:0] k);
		logic signed [SAMPLE_W-1:0] v;
		case (k)
			4'd0:    v = 8'sd120;
			4'd1:    v = 8'sd97;
			4'd2:    v = 8'sd37;
			4'd3:    v = -8'sd37;
			4'd4:    v = -8'sd97;
			4'd5:    v = -8'sd120;
			4'd6:    v = -8'sd97;
			4'd7:    v = -8'sd37;
			4'd8:    v = 8'sd37;
			4'd9:    v = 8'sd97;
			default: v = 8'sd0;
		endcase
		return v;
	endfunction

	// 120*sin(2*pi*k/10), truncated toward zero
	function automatic logic signed [SAMPLE_W-1:0] q_sample(input logic [TONE_W-1:0] k);
		logic signed [SAMPLE_W-1:0] v;
		case (k)
			4'd0:    v = 8'sd0;
			4'd1:    v = 8'sd70;
			4'd2:    v = 8'sd114;
			4'd3:    v = 8'sd114;
			4'd4:    v = 8'sd70;
			4'd5:    v = 8'sd0;
			4'd6:    v = -8'sd70;
			4'd7:    v = -8'sd114;
			4'd8:    v = -8'sd114;
			4'd9:    v = -8'sd70;
			default: v = 8'sd0;
		endcase
		return v;
	endfunction

endpackage

// ===== src/bfsk_frame_store.sv =====
// ----------------------------------------------------------------------------
// bfsk_frame_store
// Register file holding the frame bytes; one write port, one read port.
// ----------------------------------------------------------------------------
module bfsk_frame_store
	import bfsk_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [POS_W-1:0]  wr_addr,
	input  logic [BYTE_W-1:0] wr_data,
	input  logic [POS_W-1:0]  rd_addr,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] store_q [FRAME_BYTES];

	// byte write, contents undefined until written
	always_ff @(posedge clk) begin
		if (we) begin
			store_q[wr_addr] <= wr_data;
		end
	end

	// read at the current byte position
	assign rd_data = store_q[rd_addr];

endmodule

// ===== src/bfsk_seq.sv =====
// ----------------------------------------------------------------------------
// bfsk_seq
// Byte, bit, sample and tone counters that walk through the frame.
// ----------------------------------------------------------------------------
module bfsk_seq
	import bfsk_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [SPB_W-1:0]  bit_samples,
	input  logic [LEN_W-1:0]  frame_length,
	output seq_status_t       status
);

	logic [POS_W-1:0]  byte_q;
	logic [BIT_W-1:0]  bit_q;
	logic [SPB_W-1:0]  sample_q;
	logic [TONE_W-1:0] tone_q;

	logic [SPB_W-1:0]  spb_eff;
	logic [LEN_W-1:0]  len_eff;
	logic              last_sample;
	logic              last_bit;
	logic              last_byte;
	logic              byte_wrap;

	// clamp register values into their working range
	always_comb begin
		spb_eff = (bit_samples == '0) ? SPB_W'(1) : bit_samples;
		if (frame_length == '0) begin
			len_eff = LEN_W'(1);
		end else if (frame_length > LEN_W'(FRAME_BYTES)) begin
			len_eff = LEN_W'(FRAME_BYTES);
		end else begin
			len_eff = frame_length;
		end
	end

	// end-of-unit flags
	always_comb begin
		last_sample = ({1'b0, sample_q} + (SPB_W+1)'(1)) >= {1'b0, spb_eff};
		last_bit    = (bit_q == '1);
		last_byte   = ({1'b0, byte_q} == (len_eff - LEN_W'(1)));
		byte_wrap   = ({1'b0, byte_q} + LEN_W'(1)) >= len_eff;
	end

	// counters advance once per sample item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q   <= '0;
			bit_q    <= '0;
			sample_q <= '0;
			tone_q   <= '0;
		end else if (advance) begin
			if (!last_sample) begin
				sample_q <= sample_q + SPB_W'(1);
				tone_q   <= (tone_q == TONE_W'(TONE_PERIOD - 1)) ? '0 : tone_q + TONE_W'(1);
			end else begin
				sample_q <= '0;
				tone_q   <= '0;
				if (!last_bit) begin
					bit_q <= bit_q + BIT_W'(1);
				end else begin
					bit_q  <= '0;
					byte_q <= byte_wrap ? '0 : byte_q + POS_W'(1);
				end
			end
		end
	end

	// position of the sample now due
	always_comb begin
		status.byte_pos  = byte_q;
		status.bit_pos   = bit_q;
		status.tone      = tone_q;
		status.frame_end = last_sample && last_bit && last_byte;
	end

	// tone index stays inside one table period
	a_tone_range: assert property (@(posedge clk) disable iff (!arst_n)
		tone_q < TONE_W'(TONE_PERIOD))
		else $error("tone index out of range");

	// the last sample of a bit restarts the tone phase
	a_bit_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_sample |=> sample_q == '0 && tone_q == '0)
		else $error("tone phase not restarted at bit boundary");

	// frame end always falls on the last bit of a byte
	a_frame_end_bit: assert property (@(posedge clk) disable iff (!arst_n)
		status.frame_end |-> bit_q == '1 && last_sample)
		else $error("frame end off a bit boundary");

endmodule

// ===== src/bfsk_iq_modulator.sv =====
// ----------------------------------------------------------------------------
// bfsk_iq_modulator
// Binary FSK I/Q sample source: frame bytes are loaded by write items and
// each sample item yields one signed I/Q sample of a tone at fs/10.
// ----------------------------------------------------------------------------
// Path: an accepted sample item passes the input register, then the output
//   register, held while the output stalls; write items give no result.
// Throughput: one item per cycle, sustained while the output is not stalled;
//   the frame store read and tone table lookup sit between the two registers.
// Reset: counters clear and the registers return to 400 samples per bit and a
//   32-byte frame; the frame store is not cleared and must be written first.
module bfsk_iq_modulator
	import bfsk_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration write port
	input  logic                       cfg_we,
	input  logic [REG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	// item input
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       opcode,
	input  logic [POS_W-1:0]           byte_index,
	input  logic [BYTE_W-1:0]          byte_value,
	// sample output
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] in_phase,
	output logic signed [SAMPLE_W-1:0] quadrature,
	output logic                       frame_end
);

	logic [SPB_W-1:0]  spb_q;
	logic [LEN_W-1:0]  flen_q;

	logic              valid_s1;
	opcode_t           op_s1;
	logic [POS_W-1:0]  index_s1;
	logic [BYTE_W-1:0] value_s1;

	logic              out_valid_q;
	logic signed [SAMPLE_W-1:0] i_q;
	logic signed [SAMPLE_W-1:0] q_q;
	logic              frame_end_q;

	logic              out_free;
	logic              store_we;
	logic              sample_fire;
	logic              s1_done;
	logic [BYTE_W-1:0] rd_byte;
	logic              tx_bit;
	logic signed [SAMPLE_W-1:0] q_tone;
	seq_status_t       seq_st;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spb_q  <= SPB_RESET;
			flen_q <= FLEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPB:          spb_q  <= cfg_data;
				REG_FRAME_LENGTH: flen_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// stage handshake
	always_comb begin
		out_free    = !out_valid_q || !out_stall;
		store_we    = valid_s1 && (op_s1 == OP_WRITE);
		sample_fire = valid_s1 && (op_s1 == OP_SAMPLE) && out_free;
		s1_done     = store_we || sample_fire;
		in_stall    = valid_s1 && !s1_done;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1    <= opcode_t'(opcode);
			index_s1 <= byte_index;
			value_s1 <= byte_value;
		end
	end

	bfsk_frame_store u_store (
		.clk     (clk),
		.we      (store_we),
		.wr_addr (index_s1),
		.wr_data (value_s1),
		.rd_addr (seq_st.byte_pos),
		.rd_data (rd_byte)
	);

	bfsk_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (sample_fire),
		.bit_samples  (spb_q),
		.frame_length (flen_q),
		.status       (seq_st)
	);

	// bit select, msb first, and tone lookup
	always_comb begin
		tx_bit = rd_byte[~seq_st.bit_pos];
		q_tone = q_sample(seq_st.tone);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= sample_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_fire) begin
			i_q         <= i_sample(seq_st.tone);
			q_q         <= tx_bit ? -q_tone : q_tone;
			frame_end_q <= seq_st.frame_end;
		end
	end

	assign out_valid  = out_valid_q;
	assign in_phase   = i_q;
	assign quadrature = q_q;
	assign frame_end  = frame_end_q;

	// input side stalls only while a sample item waits on a full output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && op_s1 == OP_SAMPLE && out_valid_q && out_stall)
		else $error("input stalled without a blocked sample item");

	// a write item never produces a result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		store_we && !(out_valid_q && out_stall) |=> !out_valid_q)
		else $error("write item produced a result");

	// a sample item always leaves a result behind
	a_sample_result: assert property (@(posedge clk) disable iff (!arst_n)
		sample_fire |=> out_valid_q)
		else $error("sample item lost");

endmodule

// ===== dv/tb_bfsk_iq_modulator.sv =====
// ----------------------------------------------------------------------------
// tb_bfsk_iq_modulator
// Self-checking bench for the binary FSK I/Q modulator. The frame store is
// filled first, then sample and write items run through several register
// settings, from the zero and out-of-range lengths up to the longest bit.
// Each accepted item updates a local copy of the bit sequencer, and every
// output sample is compared with the oldest predicted sample. Both sides
// idle at random except in the final phase and in phases chosen to run calm.
// ----------------------------------------------------------------------------
module tb_bfsk_iq_modulator;
	import bfsk_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int MAX_REPORTS    = 10;
	localparam int PHASES         = 10;
	localparam int PHASE_ITEMS    = 85;

	typedef struct {
		opcode_t            op;
		logic [POS_W-1:0]   idx;
		logic [BYTE_W-1:0]  val;
	} mod_item_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] i;
		logic signed [SAMPLE_W-1:0] q;
		logic                       fend;
	} iq_sample_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [REG_IDX_W-1:0]       cfg_index;
	logic [CFG_W-1:0]           cfg_data;
	logic                       in_valid;
	logic                       in_stall;
	logic                       opcode;
	logic [POS_W-1:0]           byte_index;
	logic [BYTE_W-1:0]          byte_value;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [SAMPLE_W-1:0] in_phase;
	logic signed [SAMPLE_W-1:0] quadrature;
	logic                       frame_end;

	// one 10-step cycle of 120*cos and 120*sin, truncated toward zero
	const logic signed [SAMPLE_W-1:0] cos_tab [10] =
		'{8'sd120, 8'sd97, 8'sd37, -8'sd37, -8'sd97, -8'sd120, -8'sd97, -8'sd37, 8'sd37, 8'sd97};
	const logic signed [SAMPLE_W-1:0] sin_tab [10] =
		'{8'sd0, 8'sd70, 8'sd114, 8'sd114, 8'sd70, 8'sd0, -8'sd70, -8'sd114, -8'sd114, -8'sd70};

	// local copy of the modulator state
	logic [BYTE_W-1:0] frame_copy [FRAME_BYTES];
	int unsigned       cur_byte, cur_bit, cur_sample, cur_tone;
	int unsigned       spb_reg, flen_reg;

	mod_item_t  pend_q [$];
	iq_sample_t sample_q [$];

	bit          calm;
	bit          in_fire;
	int          gap_left, stall_left;
	int          errors, idle_cycles;
	mod_item_t   next_item;
	iq_sample_t  want;

	bfsk_iq_modulator i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.byte_index (byte_index),
		.byte_value (byte_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.in_phase   (in_phase),
		.quadrature (quadrature),
		.frame_end  (frame_end)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// apply one item to the local state, queue the sample it produces
	function automatic void advance_tone(input opcode_t op, input logic [POS_W-1:0] idx,
			input logic [BYTE_W-1:0] val);
		int unsigned spb, len, k;
		logic        tone_bit;
		bit          last_sample, last_bit, last_byte;
		iq_sample_t  s;
		if (op == OP_WRITE) begin
			frame_copy[idx] = val;
			return;
		end
		spb = (spb_reg == 0) ? 1 : spb_reg;
		len = (flen_reg == 0) ? 1 : ((flen_reg > FRAME_BYTES) ? FRAME_BYTES : flen_reg);
		tone_bit = frame_copy[cur_byte][7 - cur_bit];
		k = cur_tone % 10;
		s.i = cos_tab[k];
		s.q = tone_bit ? -sin_tab[k] : sin_tab[k];
		last_sample = (cur_sample + 1) >= spb;
		last_bit    = cur_bit >= 7;
		last_byte   = cur_byte == len - 1;
		s.fend = last_sample && last_bit && last_byte;
		sample_q.push_back(s);
		// counters past a shrunk limit finish the unit, then wrap
		if (!last_sample) begin
			cur_sample++;
			cur_tone = (cur_tone + 1) % TONE_PERIOD;
		end else begin
			cur_sample = 0;
			cur_tone = 0;
			if (!last_bit) begin
				cur_bit++;
			end else begin
				cur_bit = 0;
				cur_byte = (cur_byte + 1 >= len) ? 0 : cur_byte + 1;
			end
		end
	endfunction

	function automatic void note_mismatch(input string what);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("mismatch: %s", what);
	endfunction

	// item driver, changes on the falling edge
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				gap_left = $urandom_range(0, 3);
				in_valid <= 1'b0;
			end else if (pend_q.size() > 0) begin
				next_item = pend_q.pop_front();
				in_valid   <= 1'b1;
				opcode     <= next_item.op;
				byte_index <= next_item.idx;
				byte_value <= next_item.val;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output stall bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// sample checker, prediction and watchdog
	always @(posedge clk) begin
		in_fire = arst_n && in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (sample_q.size() == 0) begin
				note_mismatch($sformatf("unexpected sample i=%0d q=%0d end=%b",
					in_phase, quadrature, frame_end));
			end else begin
				want = sample_q.pop_front();
				if (in_phase !== want.i || quadrature !== want.q || frame_end !== want.fend)
					note_mismatch($sformatf("exp i=%0d q=%0d end=%b, got i=%0d q=%0d end=%b",
						want.i, want.q, want.fend, in_phase, quadrature, frame_end));
			end
		end
		if (in_fire)
			advance_tone(opcode_t'(opcode), byte_index, byte_value);
		if (!arst_n || in_fire || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic push_item(input opcode_t op, input logic [POS_W-1:0] idx,
			input logic [BYTE_W-1:0] val);
		mod_item_t it;
		it.op = op;
		it.idx = idx;
		it.val = val;
		pend_q.push_back(it);
	endtask

	// wait until every item is taken and every sample has come out
	task automatic wait_idle();
		do @(posedge clk);
		while (pend_q.size() != 0 || in_valid || sample_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input int unsigned data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(data);
		if (idx == REG_SPB)
			spb_reg = data & 12'hFFF;
		else
			flen_reg = data & 6'h3F;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// stimulus
	initial begin
		int unsigned spb_set [PHASES];
		int unsigned len_set [PHASES];
		spb_set    = '{0, 1, 3, 4095, 2, 13, 1, 25, 6, 1};
		len_set    = '{0, 1, 2, 63, 33, 3, 32, 4, 5, 2};
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = REG_SPB;
		cfg_data   = '0;
		in_valid   = 1'b0;
		opcode     = OP_WRITE;
		byte_index = '0;
		byte_value = '0;
		out_stall  = 1'b0;
		calm       = 1'b0;
		errors     = 0;
		idle_cycles = 0;
		gap_left   = 0;
		stall_left = 0;
		cur_byte   = 0;
		cur_bit    = 0;
		cur_sample = 0;
		cur_tone   = 0;
		spb_reg    = SPB_RESET;
		flen_reg   = FLEN_RESET;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fill the whole store: preamble-like pattern, all-zero, all-one, single bits
		push_item(OP_WRITE, 5'd0, 8'hAA);
		push_item(OP_WRITE, 5'd1, 8'h00);
		push_item(OP_WRITE, 5'd2, 8'hFF);
		push_item(OP_WRITE, 5'd3, 8'h55);
		push_item(OP_WRITE, 5'd4, 8'h80);
		push_item(OP_WRITE, 5'd5, 8'h01);
		for (int n = 6; n < FRAME_BYTES; n++)
			push_item(OP_WRITE, POS_W'(n), BYTE_W'($urandom));
		// reset settings: tone steps run past one table cycle inside the first bit
		for (int n = 0; n < 12; n++)
			push_item(OP_SAMPLE, POS_W'($urandom), BYTE_W'($urandom));
		wait_idle();

		// register settings from zero and out-of-range values up to the longest bit
		for (int p = 0; p < PHASES; p++) begin
			cfg_write(REG_SPB, spb_set[p]);
			cfg_write(REG_FRAME_LENGTH, len_set[p]);
			calm = (p == PHASES - 1) || ($urandom_range(0, 4) == 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 9) < 8)
					push_item(OP_SAMPLE, POS_W'($urandom), BYTE_W'($urandom));
				else
					push_item(OP_WRITE, POS_W'($urandom), BYTE_W'($urandom));
			end
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (errors == 0 && sample_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== bfsk_iq_modulator.f =====
src/bfsk_pkg.sv
src/bfsk_frame_store.sv
src/bfsk_seq.sv
src/bfsk_iq_modulator.sv
dv/tb_bfsk_iq_modulator.sv
